// ===== rtl/vsmu_pkg.sv =====
`timescale 1ns / 1ps

package vsmu_pkg;

    // Result word width and fixed-point constants
    localparam int VALUE_W = 18;
    localparam logic [VALUE_W-1:0] Q_ONE = 18'd65536;
    localparam logic [VALUE_W-1:0] Q_CAP = 18'd131072;

    // 1.0 in signed Q8.8
    localparam int ONE_Q88 = 256;

    // Quotient bits produced by the shared divider (integer bit plus 16 fraction bits)
    localparam int DIV_STEPS = 17;

    // Metric select codes
    localparam logic [1:0] MODE_COS = 2'd0;
    localparam logic [1:0] MODE_HAM = 2'd1;
    localparam logic [1:0] MODE_JAC = 2'd2;

endpackage

// ===== rtl/vector_similarity_metric_unit.sv =====
`timescale 1ns / 1ps

// Vector similarity unit: element pairs of two vectors (signed Q8.8) arrive on the s_ channel,
// and the pair marked s_last produces one word on the m_ channel: cosine distance (Q2.16),
// Hamming mismatch count or Jaccard coefficient (Q2.16, at most 1.0), as selected by the mode register.
// One multiplier is shared for a*b, a*a and b*b, so each pair passes through accept,
// the three multiplies and the last accumulate.
// At the end of a vector, Hamming, the unused mode, a zero norm and an empty Jaccard union
// go straight to the output; Jaccard runs the 17-step restoring divider, and cosine runs two bit-pair
// square roots in one shared root unit, the norm product on the shared multiplier, then the divider.
// The block takes no pair until the result word has been accepted.
// Pairs beyond MAX_LEN are dropped and flagged with m_count_saturated.
module vector_similarity_metric_unit
    import vsmu_pkg::*;
#(
    parameter int MAX_LEN    = 4096,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [ELEM_WIDTH-1:0] s_elem_a,
    input  logic signed [ELEM_WIDTH-1:0] s_elem_b,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [VALUE_W-1:0]           m_metric_value,
    output logic                         m_zero_norm,
    output logic                         m_count_saturated
);

    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int PC_W    = $clog2(MAX_LEN + 2);
    localparam int ACC_RAW = 2 * ELEM_WIDTH + CNT_W;
    localparam int ACC_W   = (ACC_RAW > 64) ? 64 : ACC_RAW;
    localparam int SQ_W    = ACC_W + (ACC_W % 2);
    localparam int RT_W    = SQ_W / 2;
    localparam int MUL_W   = (ELEM_WIDTH > RT_W + 1) ? ELEM_WIDTH : RT_W + 1;
    localparam int PRD_W   = 2 * MUL_W;
    localparam int PX_W    = (PRD_W > ACC_W) ? PRD_W : ACC_W;
    localparam int DEN_W   = 2 * RT_W;
    localparam int SUM_W   = CNT_W + 2;
    localparam int DV_M1   = (DEN_W > ACC_W) ? DEN_W : ACC_W;
    localparam int DV_W    = ((DV_M1 > SUM_W) ? DV_M1 : SUM_W) + 1;
    localparam logic [SQ_W-1:0] SQ_TOP = {2'b01, {(SQ_W-2){1'b0}}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAB  = 4'd1;
    localparam logic [3:0] S_MAA  = 4'd2;
    localparam logic [3:0] S_MBB  = 4'd3;
    localparam logic [3:0] S_MADD = 4'd4;
    localparam logic [3:0] S_DISP = 4'd5;
    localparam logic [3:0] S_SQA  = 4'd6;
    localparam logic [3:0] S_SQB  = 4'd7;
    localparam logic [3:0] S_DMUL = 4'd8;
    localparam logic [3:0] S_DCHK = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_POST = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]                   state_reg;
    logic [1:0]                   mode_reg;
    logic signed [ELEM_WIDTH-1:0] a_reg, b_reg;
    logic                         last_reg, acc_en_reg;
    logic signed [PRD_W-1:0]      prod_reg;
    logic [ACC_W-1:0]             dot_reg, na_reg, nb_reg;
    logic [CNT_W-1:0]             mis_reg, both_reg, oa_reg, ob_reg;
    logic [PC_W-1:0]              pair_reg;
    logic [SQ_W-1:0]              sq_x_reg, sq_res_reg, sq_bit_reg;
    logic [RT_W-1:0]              ra_reg, rb_reg;
    logic [DV_W-1:0]              dv_r_reg, dv_d_reg;
    logic [4:0]                   dv_cnt_reg;
    logic [VALUE_W-1:0]           q_reg;
    logic                         m_valid_reg, zero_reg, sat_reg;
    logic [VALUE_W-1:0]           value_reg;

    logic signed [MUL_W-1:0] mul_x, mul_y;
    logic signed [PRD_W-1:0] mul_p;
    logic signed [PX_W-1:0]  prod_x;
    logic [ACC_W-1:0]        prod_acc;
    logic [SQ_W-1:0]         sq_sum, sq_x_n, sq_res_n;
    logic                    sq_ge;
    logic [DV_W-1:0]         dv_rr, dv_sub, dv_den2;
    logic                    dv_ge;
    logic                    dot_neg;
    logic [ACC_W-1:0]        dot_mag;
    logic [DEN_W-1:0]        den;
    logic [SUM_W-1:0]        jsum;
    logic [VALUE_W:0]        cos_neg_sum;
    logic [VALUE_W-1:0]      post_val, fin_val;
    logic                    fin, fin_zero;
    logic                    a_one, b_one, a_zero, b_zero;

    // Shared multiplier operand select
    always_comb begin
        case (state_reg)
            S_MAB: begin
                mul_x = MUL_W'(a_reg);
                mul_y = MUL_W'(b_reg);
            end
            S_MAA: begin
                mul_x = MUL_W'(a_reg);
                mul_y = MUL_W'(a_reg);
            end
            S_MBB: begin
                mul_x = MUL_W'(b_reg);
                mul_y = MUL_W'(b_reg);
            end
            default: begin
                mul_x = $signed({{(MUL_W-RT_W){1'b0}}, ra_reg});
                mul_y = $signed({{(MUL_W-RT_W){1'b0}}, rb_reg});
            end
        endcase
    end

    assign mul_p    = mul_x * mul_y;
    assign prod_x   = PX_W'(prod_reg);
    assign prod_acc = prod_x[ACC_W-1:0];

    // Shared square-root step, two bits of radicand per cycle
    assign sq_sum   = sq_res_reg + sq_bit_reg;
    assign sq_ge    = sq_x_reg >= sq_sum;
    assign sq_x_n   = sq_ge ? (sq_x_reg - sq_sum) : sq_x_reg;
    assign sq_res_n = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);

    // Shared restoring divider step
    assign dv_rr  = (dv_cnt_reg == 5'd0) ? dv_r_reg : {dv_r_reg[DV_W-2:0], 1'b0};
    assign dv_ge  = dv_rr >= dv_d_reg;
    assign dv_sub = dv_rr - dv_d_reg;

    // Cosine operands and the Jaccard denominator
    assign dot_neg = dot_reg[ACC_W-1];
    assign dot_mag = dot_neg ? (~dot_reg + ACC_W'(1)) : dot_reg;
    assign den     = prod_reg[DEN_W-1:0];
    assign dv_den2 = DV_W'(den) << 1;
    assign jsum    = SUM_W'(both_reg) + SUM_W'(oa_reg) + SUM_W'(ob_reg);

    // Jaccard set membership of the incoming pair
    assign a_one  = s_elem_a == ONE_Q88;
    assign b_one  = s_elem_b == ONE_Q88;
    assign a_zero = s_elem_a == '0;
    assign b_zero = s_elem_b == '0;

    // Map quotient to the final metric
    assign cos_neg_sum = {1'b0, q_reg} + {1'b0, Q_ONE};
    always_comb begin
        if (mode_reg == MODE_JAC) begin
            post_val = q_reg;
        end else if (dot_neg) begin
            post_val = (cos_neg_sum > {1'b0, Q_CAP}) ? Q_CAP : cos_neg_sum[VALUE_W-1:0];
        end else begin
            post_val = (q_reg >= Q_ONE) ? '0 : (Q_ONE - q_reg);
        end
    end

    // Decide when a result word is ready
    always_comb begin
        fin      = 1'b0;
        fin_val  = '0;
        fin_zero = 1'b0;
        case (state_reg)
            S_DISP: begin
                case (mode_reg)
                    MODE_COS: begin
                        if (na_reg == '0 || nb_reg == '0) begin
                            fin      = 1'b1;
                            fin_zero = 1'b1;
                        end
                    end
                    MODE_HAM: begin
                        fin     = 1'b1;
                        fin_val = VALUE_W'(mis_reg);
                    end
                    MODE_JAC: begin
                        fin = (jsum == '0);
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_POST: begin
                fin     = 1'b1;
                fin_val = post_val;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_COS;
            m_valid_reg <= 1'b0;
            acc_en_reg  <= 1'b0;
            last_reg    <= 1'b0;
            dot_reg     <= '0;
            na_reg      <= '0;
            nb_reg      <= '0;
            mis_reg     <= '0;
            both_reg    <= '0;
            oa_reg      <= '0;
            ob_reg      <= '0;
            pair_reg    <= '0;
            dv_cnt_reg  <= '0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            case (state_reg)
                // Take a pair and update the counts
                S_IDLE: begin
                    if (s_valid) begin
                        a_reg    <= s_elem_a;
                        b_reg    <= s_elem_b;
                        last_reg <= s_last;
                        if (pair_reg < PC_W'(MAX_LEN)) begin
                            acc_en_reg <= 1'b1;
                            pair_reg   <= pair_reg + PC_W'(1);
                            if (s_elem_a != s_elem_b) begin
                                mis_reg <= mis_reg + CNT_W'(1);
                            end
                            if (a_one && b_one) begin
                                both_reg <= both_reg + CNT_W'(1);
                            end else if (a_one && b_zero) begin
                                oa_reg <= oa_reg + CNT_W'(1);
                            end else if (a_zero && b_one) begin
                                ob_reg <= ob_reg + CNT_W'(1);
                            end
                        end else begin
                            acc_en_reg <= 1'b0;
                            pair_reg   <= PC_W'(MAX_LEN + 1);
                        end
                        state_reg <= S_MAB;
                    end
                end
                S_MAB: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MAA;
                end
                S_MAA: begin
                    prod_reg <= mul_p;
                    if (acc_en_reg) begin
                        dot_reg <= dot_reg + prod_acc;
                    end
                    state_reg <= S_MBB;
                end
                S_MBB: begin
                    prod_reg <= mul_p;
                    if (acc_en_reg) begin
                        na_reg <= na_reg + prod_acc;
                    end
                    state_reg <= S_MADD;
                end
                S_MADD: begin
                    if (acc_en_reg) begin
                        nb_reg <= nb_reg + prod_acc;
                    end
                    state_reg <= last_reg ? S_DISP : S_IDLE;
                end
                // Start the end-of-vector work
                S_DISP: begin
                    sq_x_reg   <= SQ_W'(na_reg);
                    sq_res_reg <= '0;
                    sq_bit_reg <= SQ_TOP;
                    dv_r_reg   <= DV_W'(both_reg);
                    dv_d_reg   <= DV_W'(jsum);
                    dv_cnt_reg <= '0;
                    q_reg      <= '0;
                    state_reg  <= fin ? S_OUT : ((mode_reg == MODE_JAC) ? S_DIV : S_SQA);
                end
                S_SQA: begin
                    sq_x_reg   <= sq_x_n;
                    sq_res_reg <= sq_res_n;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) begin
                        ra_reg     <= sq_res_n[RT_W-1:0];
                        sq_x_reg   <= SQ_W'(nb_reg);
                        sq_res_reg <= '0;
                        sq_bit_reg <= SQ_TOP;
                        state_reg  <= S_SQB;
                    end
                end
                S_SQB: begin
                    sq_x_reg   <= sq_x_n;
                    sq_res_reg <= sq_res_n;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) begin
                        rb_reg    <= sq_res_n[RT_W-1:0];
                        state_reg <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_DCHK;
                end
                // Saturate the quotient when |dot| reaches twice the norm product, else start the divider
                S_DCHK: begin
                    dv_d_reg   <= DV_W'(den);
                    dv_r_reg   <= DV_W'(dot_mag);
                    dv_cnt_reg <= '0;
                    if (DV_W'(dot_mag) >= dv_den2) begin
                        q_reg     <= Q_CAP;
                        state_reg <= S_POST;
                    end else begin
                        q_reg     <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    dv_r_reg   <= dv_ge ? dv_sub : dv_rr;
                    q_reg      <= {q_reg[VALUE_W-2:0], dv_ge};
                    dv_cnt_reg <= dv_cnt_reg + 5'd1;
                    if (dv_cnt_reg == 5'(DIV_STEPS - 1)) begin
                        state_reg <= S_POST;
                    end
                end
                S_POST: begin
                    state_reg <= S_OUT;
                end
                // Hold the word until taken
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            // Register the result and clear the accumulators
            if (fin) begin
                value_reg   <= fin_val;
                zero_reg    <= fin_zero;
                sat_reg     <= pair_reg > PC_W'(MAX_LEN);
                m_valid_reg <= 1'b1;
                dot_reg     <= '0;
                na_reg      <= '0;
                nb_reg      <= '0;
                mis_reg     <= '0;
                both_reg    <= '0;
                oa_reg      <= '0;
                ob_reg      <= '0;
                pair_reg    <= '0;
            end
        end
    end

    assign s_ready           = state_reg == S_IDLE;
    assign m_valid           = m_valid_reg;
    assign m_metric_value    = value_reg;
    assign m_zero_norm       = zero_reg;
    assign m_count_saturated = sat_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while a result word is pending");

    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pair_reg == '0 && dot_reg == '0 && mis_reg == '0))
        else $error("accumulators not cleared after result");

    a_zero_val: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_norm) |-> (m_metric_value == '0))
        else $error("zero norm flag with nonzero value");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_metric_value <= Q_CAP))
        else $error("result word out of range");

endmodule
